// File: src/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and codes of the receive byte FIFO with line reader.
// ----------------------------------------------------------------------------
package rbf_pkg;

   localparam int MODE_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 7;
   localparam int KIND_W      = 3;
   localparam int FILL_W      = 8;
   localparam int LEN_W       = 10;
   localparam int LIMIT_W     = 11;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BURST = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LINE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ACK       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DATA      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LINE_CHAR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LINE_END  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISCARD   = 3'd4;

   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

   localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 11'd128;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BYTE_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              dropped;
      logic [FILL_W-1:0] fill;
      logic [LEN_W-1:0]  len;
   } rsp_type;

endpackage

// File: src/rbf_front.sv
// ----------------------------------------------------------------------------
// rbf_front
// Accepts request beats, caps the burst count and queues the commands.
// ----------------------------------------------------------------------------
module rbf_front #(
   parameter int MAX_BURST = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rbf_pkg::MODE_W-1:0]     req_mode,
   input  logic [rbf_pkg::BYTE_W-1:0]     req_data,
   input  logic [rbf_pkg::COUNT_W-1:0]    req_count,
   output logic                           cmd_valid,
   output rbf_pkg::cmd_type               cmd,
   input  logic                           cmd_pop
);

   localparam logic [rbf_pkg::COUNT_W-1:0] BURST_CAP = rbf_pkg::COUNT_W'(MAX_BURST);

   rbf_pkg::cmd_type q_ff [2];
   rbf_pkg::cmd_type new_cmd;
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;

   always_comb begin
      new_cmd.mode  = req_mode;
      new_cmd.data  = req_data;
      new_cmd.count = (req_count > BURST_CAP) ? BURST_CAP : req_count;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (cmd_pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

endmodule

// File: src/rbf_back.sv
// ----------------------------------------------------------------------------
// rbf_back
// Executes queued commands on the byte ring and drives the result register.
// ----------------------------------------------------------------------------
module rbf_back #(
   parameter int FIFO_DEPTH = 256,
   parameter int MAX_LINE   = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  rbf_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   input  logic [rbf_pkg::LIMIT_W-1:0]   line_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rbf_pkg::rsp_type              rsp
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int MW = (PW > rbf_pkg::COUNT_W) ? PW : rbf_pkg::COUNT_W;
   localparam int IW = $clog2(MAX_LINE);
   localparam int LW = ($clog2(MAX_LINE + 1) > rbf_pkg::LIMIT_W) ?
                       $clog2(MAX_LINE + 1) : rbf_pkg::LIMIT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [rbf_pkg::BYTE_W-1:0] byte_store [FIFO_DEPTH];

   logic [1:0]                  state_ff, state_in;
   logic [PW-1:0]               wp_ff, wp_in;
   logic [PW-1:0]               rp_ff, rp_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [rbf_pkg::COUNT_W-1:0] rem_ff, rem_in;
   rbf_pkg::cmd_type            cmd_ff, cmd_in;
   rbf_pkg::rsp_type            out_ff, out_in;
   logic                        out_valid_ff, out_valid_in;
   logic [rbf_pkg::BYTE_W-1:0]  rdata_ff;

   logic                        out_free;
   logic                        wr_en;
   logic                        emit;
   rbf_pkg::rsp_type            res;
   logic [PW-1:0]               fill_now;
   logic [PW-1:0]               fill_next;
   logic [MW-1:0]               fill_ext;
   logic [MW-1:0]               count_ext;
   logic [MW-1:0]               burst_n;
   logic [LW-1:0]               lim_ext;
   logic [LW-1:0]               lim_m1;

   function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
      logic [PW:0] diff;
      diff = {1'b0, w} - {1'b0, r};
      if (diff[PW]) begin
         diff = diff + (PW + 1)'(FIFO_DEPTH);
      end
      return diff[PW-1:0];
   endfunction

   assign fill_now  = fill_of(wp_ff, rp_ff);
   assign fill_ext  = MW'(fill_now);
   assign count_ext = MW'(cmd_ff.count);
   assign burst_n   = (count_ext < fill_ext) ? count_ext : fill_ext;

   // Clamp the line limit into [2, MAX_LINE]
   always_comb begin
      lim_ext = LW'(line_limit);
      if (lim_ext < LW'(2)) begin
         lim_ext = LW'(2);
      end else if (lim_ext > LW'(MAX_LINE)) begin
         lim_ext = LW'(MAX_LINE);
      end
      lim_m1 = lim_ext - LW'(1);
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      cmd_in       = cmd_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      emit         = 1'b0;
      res          = '0;
      res.kind     = rbf_pkg::KIND_ACK;
      res.last     = 1'b1;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               case (cmd_ff.mode)
                  rbf_pkg::MODE_PUSH: begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (wrap_next(wp_ff) == rp_ff) begin
                        res.dropped = 1'b1;
                     end else begin
                        wr_en = 1'b1;
                        wp_in = wrap_next(wp_ff);
                     end
                  end
                  rbf_pkg::MODE_CLEAR: begin
                     wp_in    = '0;
                     rp_in    = '0;
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
                  rbf_pkg::MODE_BURST: begin
                     if (burst_n == '0) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        rem_in   = rbf_pkg::COUNT_W'(burst_n);
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     if (fill_now == '0) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            // byte at the read pointer lands in rdata_ff at this edge
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit  = 1'b1;
               rp_in = wrap_next(rp_ff);
               if (cmd_ff.mode == rbf_pkg::MODE_BURST) begin
                  res.kind = rbf_pkg::KIND_DATA;
                  res.data = rdata_ff;
                  res.last = (rem_ff == rbf_pkg::COUNT_W'(1));
                  rem_in   = rem_ff - rbf_pkg::COUNT_W'(1);
                  state_in = res.last ? S_IDLE : S_READ;
               end else begin
                  state_in = S_IDLE;
                  if (rdata_ff == rbf_pkg::CH_CR) begin
                     res.kind = rbf_pkg::KIND_ACK;
                  end else if (rdata_ff == rbf_pkg::CH_LF) begin
                     res.kind = rbf_pkg::KIND_LINE_END;
                     res.len  = rbf_pkg::LEN_W'(idx_ff);
                     idx_in   = '0;
                  end else if (LW'(idx_ff) < lim_m1) begin
                     res.kind = rbf_pkg::KIND_LINE_CHAR;
                     res.data = rdata_ff;
                     idx_in   = idx_ff + IW'(1);
                  end else begin
                     res.kind = rbf_pkg::KIND_DISCARD;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      fill_next = fill_of(wp_in, rp_in);
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
         out_in.fill  = rbf_pkg::FILL_W'(fill_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         idx_ff       <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         idx_ff       <= idx_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_store[wp_ff] <= cmd_ff.data;
      end
      rdata_ff <= byte_store[rp_ff];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

// File: src/rx_byte_fifo_line_reader_unit.sv
// ----------------------------------------------------------------------------
// rx_byte_fifo_line_reader_unit
// Receive byte ring FIFO with burst read, clear and a CR/LF line reader.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                         Contents
// req      in   req_tvalid/tready/tdata/tuser   request: mode, byte, burst count
// rsp      out  rsp_tvalid/tready/tdata/tuser   result: kind, byte, fill, length
// csr      in   csr_wr_en/csr_wr_data           line_limit register
//
// Push, clear and any request that finds the FIFO empty pass from the command queue through
// the idle and execute states to the result register; a line pop adds a read and an emit state,
// and a burst read passes through both once per byte, as the byte store read is registered.
// A two-entry command queue keeps accepting while the executor runs.
// Reset is synchronous; the byte store itself is not cleared. A stalled result
// holds the executor, never the request side until the queue fills.
// ----------------------------------------------------------------------------
module rx_byte_fifo_line_reader_unit #(
   parameter int FIFO_DEPTH = 256,
   parameter int MAX_BURST  = 64,
   parameter int MAX_LINE   = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rbf_pkg::REQ_TDATA_W-1:0]    req_tdata,  // data_in[7:0], read_limit[14:8]
   input  logic [rbf_pkg::MODE_W-1:0]         req_tuser,  // mode[1:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rbf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // data_out[7:0], dropped[8],
                                                          // fill_count[16:9], line_length[26:17]
   output logic [rbf_pkg::KIND_W-1:0]         rsp_tuser,  // kind[2:0]
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [rbf_pkg::LIMIT_W-1:0]        csr_wr_data
);

   logic [rbf_pkg::LIMIT_W-1:0] line_limit_ff, line_limit_in;
   logic                        cmd_valid;
   logic                        cmd_pop;
   rbf_pkg::cmd_type            cmd;
   rbf_pkg::rsp_type            rsp;
   // unused request padding bit
   logic                        unused_req_pad;

   assign line_limit_in = csr_wr_en ? csr_wr_data : line_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= rbf_pkg::LINE_LIMIT_RESET;
      end else begin
         line_limit_ff <= line_limit_in;
      end
   end

   rbf_front #(
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .req_data  (req_tdata[7:0]),
      .req_count (req_tdata[14:8]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   rbf_back #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .MAX_LINE   (MAX_LINE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .line_limit (line_limit_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;
   assign rsp_tdata = {5'd0, rsp.len, rsp.fill, rsp.dropped, rsp.data};

   assign unused_req_pad = req_tdata[15];

endmodule

// File: src/rbf_checker.sv
// ----------------------------------------------------------------------------
// rbf_checker
// Port-level checks of the receive byte FIFO with line reader.
// ----------------------------------------------------------------------------
module rbf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rbf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [rbf_pkg::KIND_W-1:0]       rsp_tuser,
   input logic                             rsp_tlast
);

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_drop_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tlast && rsp_tuser == rbf_pkg::KIND_ACK)
      else $error("dropped flag on a non-ack result");

   a_len_only_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26:17] != 10'd0 |-> rsp_tuser == rbf_pkg::KIND_LINE_END)
      else $error("line length on a result that is not a line end");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rbf_pkg::KIND_DATA |-> rsp_tlast)
      else $error("non-burst result without last");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind rx_byte_fifo_line_reader_unit rbf_checker u_rbf_checker (.*);

// File: verif/rx_byte_fifo_line_reader_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_byte_fifo_line_reader_unit_checker
// Watches the request, result and register ports of the receive byte FIFO,
// keeps its own image of the ring, line counter and line limit, queues the
// results each accepted request must cause and compares every result beat
// with the oldest one still due.
// ----------------------------------------------------------------------------
module rx_byte_fifo_line_reader_unit_checker
   import rbf_pkg::*;
#(
   parameter int FIFO_DEPTH = 256,
   parameter int MAX_BURST  = 64,
   parameter int MAX_LINE   = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // data_in[7:0], read_limit[14:8]
   input  logic [MODE_W-1:0]      req_tuser,   // mode[1:0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // data_out[7:0], dropped[8],
                                               // fill_count[16:9], line_length[26:17]
   input  logic [KIND_W-1:0]      rsp_tuser,   // kind[2:0]
   input  logic                   rsp_tlast,
   input  logic                   csr_wr_en,
   input  logic [LIMIT_W-1:0]     csr_wr_data,
   output int                     error_count,
   output int                     due_count,
   output int                     result_count
);

   logic [BYTE_W-1:0]  fifo_image [FIFO_DEPTH];
   int                 wr_slot;
   int                 rd_slot;
   int                 line_chars;
   logic [LIMIT_W-1:0] line_limit;
   rsp_type            due_results [$];

   function automatic int held_bytes();
      return (wr_slot - rd_slot + FIFO_DEPTH) % FIFO_DEPTH;
   endfunction

   function automatic void add_due(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                   logic last, logic dropped, int len);
      rsp_type r;
      r.kind    = kind;
      r.data    = data;
      r.last    = last;
      r.dropped = dropped;
      r.fill    = FILL_W'(held_bytes());
      r.len     = LEN_W'(len);
      due_results.push_back(r);
   endfunction

   function automatic logic [BYTE_W-1:0] take_byte();
      logic [BYTE_W-1:0] b;
      b       = fifo_image[rd_slot];
      rd_slot = (rd_slot + 1) % FIFO_DEPTH;
      return b;
   endfunction

   function automatic void step_fifo_image(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] din,
                                           logic [COUNT_W-1:0] cnt);
      int                n;
      int                lim;
      int                len;
      logic [BYTE_W-1:0] ch;
      case (mode)
         MODE_PUSH: begin
            if ((wr_slot + 1) % FIFO_DEPTH == rd_slot) begin
               add_due(KIND_ACK, '0, 1'b1, 1'b1, 0);
            end else begin
               fifo_image[wr_slot] = din;
               wr_slot = (wr_slot + 1) % FIFO_DEPTH;
               add_due(KIND_ACK, '0, 1'b1, 1'b0, 0);
            end
         end
         MODE_BURST: begin
            n = cnt;
            if (n > MAX_BURST) n = MAX_BURST;
            if (n > held_bytes()) n = held_bytes();
            if (n == 0) begin
               add_due(KIND_ACK, '0, 1'b1, 1'b0, 0);
            end else begin
               for (int i = 0; i < n; i++) begin
                  ch = take_byte();
                  add_due(KIND_DATA, ch, i == n - 1, 1'b0, 0);
               end
            end
         end
         MODE_CLEAR: begin
            // line counter survives a clear
            wr_slot = 0;
            rd_slot = 0;
            add_due(KIND_ACK, '0, 1'b1, 1'b0, 0);
         end
         MODE_LINE: begin
            if (held_bytes() == 0) begin
               add_due(KIND_ACK, '0, 1'b1, 1'b0, 0);
            end else begin
               lim = line_limit;
               if (lim < 2) lim = 2;
               if (lim > MAX_LINE) lim = MAX_LINE;
               ch = take_byte();
               if (ch == CH_CR) begin
                  add_due(KIND_ACK, '0, 1'b1, 1'b0, 0);
               end else if (ch == CH_LF) begin
                  len = line_chars;
                  line_chars = 0;
                  add_due(KIND_LINE_END, '0, 1'b1, 1'b0, len);
               end else if (line_chars < lim - 1) begin
                  line_chars++;
                  add_due(KIND_LINE_CHAR, ch, 1'b1, 1'b0, 0);
               end else begin
                  add_due(KIND_DISCARD, '0, 1'b1, 1'b0, 0);
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         wr_slot      = 0;
         rd_slot      = 0;
         line_chars   = 0;
         line_limit   = LINE_LIMIT_RESET;
         error_count  = 0;
         result_count = 0;
         due_results.delete();
      end else begin
         if (csr_wr_en) line_limit = csr_wr_data;
         // a result never leaves in the beat its request is taken, so predict first
         if (req_tvalid && req_tready)
            step_fifo_image(req_tuser, req_tdata[7:0], req_tdata[14:8]);
         if (rsp_tvalid && rsp_tready) begin
            seen.kind    = rsp_tuser;
            seen.data    = rsp_tdata[7:0];
            seen.last    = rsp_tlast;
            seen.dropped = rsp_tdata[8];
            seen.fill    = rsp_tdata[16:9];
            seen.len     = rsp_tdata[26:17];
            result_count++;
            if (due_results.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: result beat with nothing due: kind %0d data %02h fill %0d",
                           $realtime, seen.kind, seen.data, seen.fill);
               error_count++;
            end else begin
               want = due_results.pop_front();
               if (seen.kind != want.kind || seen.data != want.data ||
                   seen.last != want.last || seen.dropped != want.dropped ||
                   seen.fill != want.fill || seen.len != want.len) begin
                  if (error_count < 10) begin
                     $display("%0t: mismatch (expected/actual) kind %0d/%0d data %02h/%02h",
                              $realtime, want.kind, seen.kind, want.data, seen.data);
                     $display("   last %0b/%0b dropped %0b/%0b fill %0d/%0d length %0d/%0d",
                              want.last, seen.last, want.dropped, seen.dropped,
                              want.fill, seen.fill, want.len, seen.len);
                  end
                  error_count++;
               end
            end
         end
      end
      due_count = due_results.size();
   end

endmodule

// File: verif/rx_byte_fifo_line_reader_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_byte_fifo_line_reader_unit_test
// Drives the receive byte FIFO with directed corner cases, a fill-to-capacity
// run and phases of random line, burst, clear and noise traffic under
// several line limits, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module rx_byte_fifo_line_reader_unit_test;
   import rbf_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // data_in[7:0], read_limit[14:8]
   logic [MODE_W-1:0]      req_tuser = MODE_PUSH;   // mode[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // data_out[7:0], dropped[8], fill[16:9], len[26:17]
   logic [KIND_W-1:0]      rsp_tuser;   // kind[2:0]
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]     csr_wr_data = '0;

   int error_count;
   int due_count;
   int result_count;

   int sent_count;
   int mode_count [4];
   int burst_left;
   int quiet_left;
   int stall_left;
   int stall_style;

   always #5 clock = ~clock;

   rx_byte_fifo_line_reader_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rx_byte_fifo_line_reader_unit_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .error_count  (error_count),
      .due_count    (due_count),
      .result_count (result_count)
   );

   // result side: switch between stall styles at random intervals
   always @(negedge clock) begin
      logic ready;
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(8, 40);
      end
      stall_left--;
      case (stall_style)
         0:       ready = 1'b1;
         1:       ready = $urandom_range(0, 1);
         2:       ready = ($urandom_range(0, 3) == 0);
         default: ready = ($urandom_range(0, 11) == 0);
      endcase
      rsp_tready <= ready;
   end

   task automatic send(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] din,
                       input logic [COUNT_W-1:0] cnt);
      int gap;
      if (burst_left == 0) begin
         if (quiet_left == 0 && $urandom_range(0, 9) == 0) quiet_left = $urandom_range(20, 60);
         gap = (quiet_left > 0) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, cnt, din};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (quiet_left > 0) quiet_left--;
      sent_count++;
      mode_count[mode]++;
   endtask

   // hold off until every due result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (due_count != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [BYTE_W-1:0] line_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return CH_CR;
      if (pick == 1) return BYTE_W'($urandom_range(0, 255));
      return BYTE_W'($urandom_range(8'h20, 8'h7E));
   endfunction

   task automatic random_episode();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         // well-formed line, sometimes left open
         n = $urandom_range(0, 10);
         for (int i = 0; i < n; i++) send(MODE_PUSH, line_byte(), COUNT_W'($urandom));
         if ($urandom_range(0, 5) != 0) send(MODE_PUSH, CH_LF, COUNT_W'($urandom));
         n = n + 1 + $urandom_range(0, 2);
         for (int i = 0; i < n; i++)
            send(MODE_LINE, BYTE_W'($urandom), COUNT_W'($urandom));
      end else if (pick < 65) begin
         n = $urandom_range(0, 12);
         for (int i = 0; i < n; i++)
            send(MODE_PUSH, BYTE_W'($urandom), COUNT_W'($urandom));
         if ($urandom_range(0, 3) == 0)
            send(MODE_BURST, BYTE_W'($urandom), COUNT_W'($urandom_range(0, 127)));
         else
            send(MODE_BURST, BYTE_W'($urandom), COUNT_W'($urandom_range(1, 16)));
      end else if (pick < 75) begin
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++)
            send(MODE_PUSH, BYTE_W'($urandom), COUNT_W'($urandom));
         send(MODE_CLEAR, BYTE_W'($urandom), COUNT_W'($urandom));
      end else begin
         send(MODE_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom));
      end
   endtask

   initial begin
      logic [LIMIT_W-1:0] phase_limit [8];
      int                 phase_end;
      phase_limit = '{11'd0, 11'd1, 11'd3, 11'd1024, 11'd2047, 11'd2, 11'd7, 11'd128};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty FIFO, byte extremes, CR and LF under the reset line limit
      send(MODE_BURST, 8'h00, 7'd5);
      send(MODE_LINE, 8'hFF, 7'd0);
      send(MODE_PUSH, 8'h00, 7'd0);
      send(MODE_PUSH, 8'hFF, 7'd127);
      send(MODE_PUSH, CH_CR, 7'd0);
      send(MODE_PUSH, CH_LF, 7'd0);
      repeat (4) send(MODE_LINE, 8'h00, 7'd0);
      drain();

      // short limit: line full, then discard, then LF
      write_limit(11'd5);
      send(MODE_PUSH, 8'h41, 7'd0);
      send(MODE_PUSH, 8'h42, 7'd0);
      send(MODE_PUSH, 8'h43, 7'd0);
      send(MODE_PUSH, 8'h44, 7'd0);
      send(MODE_PUSH, 8'h45, 7'd0);
      send(MODE_PUSH, CH_LF, 7'd0);
      repeat (6) send(MODE_LINE, 8'h00, 7'd0);
      send(MODE_PUSH, 8'h5A, 7'd0);
      send(MODE_BURST, 8'h00, 7'd0);
      send(MODE_BURST, 8'h00, 7'd127);
      send(MODE_PUSH, 8'h11, 7'd0);
      send(MODE_CLEAR, 8'h00, 7'd0);
      send(MODE_BURST, 8'h00, 7'd3);
      drain();

      // fill to capacity with drops, then capped bursts down to empty
      for (int i = 0; i < 258; i++) send(MODE_PUSH, BYTE_W'($urandom), COUNT_W'($urandom));
      send(MODE_BURST, 8'h00, 7'd65);
      send(MODE_BURST, 8'h00, 7'd127);
      send(MODE_BURST, 8'h00, 7'd64);
      send(MODE_BURST, 8'h00, 7'd63);
      send(MODE_BURST, 8'h00, 7'd1);
      send(MODE_LINE, 8'h00, 7'd0);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_limit(phase_limit[p]);
         phase_end = sent_count + 4;
         while (sent_count < phase_end) random_episode();
         drain();
      end

      repeat (16) @(negedge clock);
      $display("covered %0d requests: %0d push, %0d burst, %0d clear, %0d line pop",
               sent_count, mode_count[MODE_PUSH], mode_count[MODE_BURST],
               mode_count[MODE_CLEAR], mode_count[MODE_LINE]);
      $display("checked %0d result beats; full FIFO with drops, capped bursts, 10 line limits",
               result_count);
      if (error_count == 0 && due_count == 0)
         $display("rx_byte_fifo_line_reader_unit_test: done, clean");
      else
         $display("rx_byte_fifo_line_reader_unit_test: done, errors");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d results still due", due_count);
      $display("rx_byte_fifo_line_reader_unit_test: done, errors");
      $finish;
   end

endmodule
